[hw/rtl/supervisory_frame_arq_receiver_assert.svh]
// Assertion macros shared by the supervisory frame ARQ receiver RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef SUPERVISORY_FRAME_ARQ_RECEIVER_ASSERT_SVH
`define SUPERVISORY_FRAME_ARQ_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SFAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfar assertion failed");

// Next-cycle implication, checked outside of reset.
`define SFAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfar assertion failed");

`endif

[hw/rtl/sfar_pkg.sv]
// Types, codes and constants of the supervisory frame ARQ receiver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sfar_pkg;

    localparam logic [7:0] FRAME_FLAG = 8'h7E;
    localparam logic [7:0] CTL_UA     = 8'h07;
    localparam logic [7:0] CTL_DISC   = 8'h0B;
    localparam logic [7:0] CTL_RR0    = 8'h05;
    localparam logic [7:0] CTL_RR1    = 8'h85;
    localparam logic [7:0] CTL_REJ0   = 8'h01;
    localparam logic [7:0] CTL_REJ1   = 8'h81;

    localparam logic [7:0]  ADDR_RESET    = 8'h03;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3;
    localparam logic [3:0]  ATTEMPT_RESET = 4'd3;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ADDRESS = 2'd0,
        REG_TIMEOUT = 2'd1,
        REG_ATTEMPTS = 2'd2
    } t_reg_index;

    typedef enum logic [3:0] {
        RES_NONE      = 4'd0,
        RES_RR0       = 4'd1,
        RES_RR1       = 4'd2,
        RES_REJ0      = 4'd3,
        RES_REJ1      = 4'd4,
        RES_DISC      = 4'd5,
        RES_UNKNOWN   = 4'd6,
        RES_UA_SENT   = 4'd7,
        RES_EXHAUSTED = 4'd8
    } t_result;

    // A received UA reply shares code zero with the idle value.
    localparam t_result RES_UA = RES_NONE;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_BCC  = 3'd4
    } t_rx_phase;

    typedef struct packed {
        logic restart;
        logic step;
    } t_rx_ctrl;

    typedef struct packed {
        logic clear;
        logic tick;
    } t_tmr_ctrl;

    typedef struct packed {
        logic timeout;
        logic exhausted;
    } t_tmr_status;

    function automatic t_result map_control(input logic [7:0] ctl);
        t_result res;
        unique case (ctl)
            CTL_UA:   res = RES_UA;
            CTL_RR0:  res = RES_RR0;
            CTL_RR1:  res = RES_RR1;
            CTL_REJ0: res = RES_REJ0;
            CTL_REJ1: res = RES_REJ1;
            CTL_DISC: res = RES_DISC;
            default:  res = RES_UNKNOWN;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/supervisory_frame_arq_receiver.sv]
// Top level of the supervisory frame ARQ receiver: handshake, registers,
// transaction state and result word. Depends on sfar_pkg, sfar_frame_rx,
// sfar_timer and the assertion macro header.
`default_nettype none

// Stop-and-wait sender control that waits for a supervisory reply frame.
// Every input word (start, received byte or timer tick) yields exactly one
// result word. The block takes one word per clock cycle while the output is
// not stalled: a word is held in the input register, and the recognizer,
// timer and transaction state are updated as it moves into the result
// register, from which its result is shown. The input register and the result
// register each hold a word, so input is taken while a result waits.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data:
// index 0 address byte, 1 timeout ticks, 2 attempt limit.
module supervisory_frame_arq_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_is_ua,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_transmit,
    output logic             o_done_res,
    output logic [3:0]       o_result_code,
    output logic             o_busy_res
);
    import sfar_pkg::*;

`include "supervisory_frame_arq_receiver_assert.svh"

    logic [7:0]  r_address;
    logic [15:0] r_timeout;
    logic [3:0]  r_max_attempts;

    logic        r_in_valid;
    logic [1:0]  r_command;
    logic [7:0]  r_rx_byte;
    logic        r_frame_is_ua;

    logic        r_out_valid;
    logic        r_transmit;
    logic        r_done;
    t_result     r_code;
    logic        r_busy;

    logic        r_waiting, n_waiting;
    logic        advance;
    logic        in_accept;
    logic        is_start, is_byte, is_tick;
    logic        frame_done;
    logic [7:0]  control_byte;
    t_rx_ctrl    rx_ctrl;
    t_tmr_ctrl   tmr_ctrl;
    t_tmr_status tmr_status;
    logic        n_transmit;
    logic        n_done;
    t_result     n_code;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address      <= ADDR_RESET;
            r_timeout      <= TIMEOUT_RESET;
            r_max_attempts <= ATTEMPT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ADDRESS:  r_address      <= i_cfg_data[7:0];
                REG_TIMEOUT:  r_timeout      <= i_cfg_data;
                REG_ATTEMPTS: r_max_attempts <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command     <= i_command;
            r_rx_byte     <= i_rx_byte;
            r_frame_is_ua <= i_frame_is_ua;
        end
    end

    assign is_start = advance && (r_command == CMD_START);
    assign is_byte  = advance && (r_command == CMD_BYTE) && r_waiting;
    assign is_tick  = advance && (r_command == CMD_TICK) && r_waiting;

    // A retransmit or a new start drops any half-received reply.
    assign rx_ctrl.restart = is_start || tmr_status.timeout;
    assign rx_ctrl.step    = is_byte;
    assign tmr_ctrl.clear  = is_start;
    assign tmr_ctrl.tick   = is_tick;

    sfar_frame_rx u_frame_rx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (rx_ctrl),
        .i_rx_byte      (r_rx_byte),
        .i_address_byte (r_address),
        .o_frame_done   (frame_done),
        .o_control_byte (control_byte)
    );

    sfar_timer u_timer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (tmr_ctrl),
        .i_timeout_ticks (r_timeout),
        .i_max_attempts  (r_max_attempts),
        .o_status        (tmr_status)
    );

    always_comb begin
        n_waiting  = r_waiting;
        n_transmit = 1'b0;
        n_done     = 1'b0;
        n_code     = RES_NONE;
        if (is_start) begin
            n_transmit = 1'b1;
            n_waiting  = !r_frame_is_ua;
            if (r_frame_is_ua) begin
                n_done = 1'b1;
                n_code = RES_UA_SENT;
            end
        end else if (frame_done) begin
            n_waiting = 1'b0;
            n_done    = 1'b1;
            n_code    = map_control(control_byte);
        end else if (tmr_status.exhausted) begin
            n_waiting = 1'b0;
            n_done    = 1'b1;
            n_code    = RES_EXHAUSTED;
        end else if (tmr_status.timeout) begin
            n_transmit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_waiting <= n_waiting;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_transmit <= n_transmit;
            r_done     <= n_done;
            r_code     <= n_code;
            r_busy     <= n_waiting;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_transmit    = r_transmit;
    assign o_done_res    = r_done;
    assign o_result_code = r_code;
    assign o_busy_res    = r_busy;

    `SFAR_ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_done, !r_busy)
    `SFAR_ASSERT_IMPL(a_code_only_when_done, i_clk, i_rst_n, r_out_valid && !r_done,
        r_code == RES_NONE)
    `SFAR_ASSERT_IMPL(a_resend_while_waiting, i_clk, i_rst_n,
        r_out_valid && r_transmit && !r_done, r_busy)
    `SFAR_ASSERT_NEXT(a_exhaust_ends_wait, i_clk, i_rst_n, tmr_status.exhausted, !r_waiting)
    `SFAR_ASSERT_NEXT(a_result_tracks_state, i_clk, i_rst_n, advance, r_busy == r_waiting)

endmodule

`default_nettype wire

[hw/rtl/sfar_frame_rx.sv]
// Reply frame recognizer: FLAG, address, control, BCC, FLAG.
// Depends on sfar_pkg for the phase type and frame constants.
`default_nettype none

module sfar_frame_rx (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfar_pkg::t_rx_ctrl i_ctrl,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic [7:0]        i_address_byte,
    output logic                   o_frame_done,
    output logic [7:0]             o_control_byte
);
    import sfar_pkg::*;

    t_rx_phase  r_phase, n_phase;
    logic [7:0] r_control, n_control;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_control <= 8'h00;
        end else begin
            r_phase   <= n_phase;
            r_control <= n_control;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_control    = r_control;
        o_frame_done = 1'b0;
        if (i_ctrl.restart) begin
            n_phase = PH_HUNT;
        end else if (i_ctrl.step) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == FRAME_FLAG) n_phase = PH_FLAG;
                end
                PH_FLAG: begin
                    // The address match is tested first, so an address equal
                    // to the flag still opens a frame.
                    if (i_rx_byte == i_address_byte)  n_phase = PH_ADDR;
                    else if (i_rx_byte == FRAME_FLAG) n_phase = PH_FLAG;
                    else                              n_phase = PH_HUNT;
                end
                PH_ADDR: begin
                    if (i_rx_byte == FRAME_FLAG) begin
                        n_phase = PH_FLAG;
                    end else begin
                        n_control = i_rx_byte;
                        n_phase   = PH_CTRL;
                    end
                end
                PH_CTRL: begin
                    if (i_rx_byte == FRAME_FLAG)                       n_phase = PH_FLAG;
                    else if (i_rx_byte == (i_address_byte ^ r_control)) n_phase = PH_BCC;
                    else                                                n_phase = PH_HUNT;
                end
                PH_BCC: begin
                    o_frame_done = (i_rx_byte == FRAME_FLAG);
                    n_phase      = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    assign o_control_byte = r_control;

endmodule

`default_nettype wire

[hw/rtl/sfar_timer.sv]
// Reply timeout and attempt counter of the supervisory frame ARQ receiver.
// Depends on sfar_pkg for the control and status structs.
`default_nettype none

module sfar_timer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sfar_pkg::t_tmr_ctrl i_ctrl,
    input  wire logic [15:0]         i_timeout_ticks,
    input  wire logic [3:0]          i_max_attempts,
    output sfar_pkg::t_tmr_status    o_status
);
    import sfar_pkg::*;

    logic [15:0] r_ticks, n_ticks;
    logic [3:0]  r_attempts, n_attempts;
    logic [15:0] ticks_inc;
    logic [3:0]  attempts_inc;
    logic        expired;

    assign ticks_inc    = r_ticks + 16'd1;
    assign attempts_inc = r_attempts + 4'd1;
    // A zero limit always compares as reached, which makes zero act as one.
    assign expired      = (ticks_inc >= i_timeout_ticks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks    <= '0;
            r_attempts <= '0;
        end else begin
            r_ticks    <= n_ticks;
            r_attempts <= n_attempts;
        end
    end

    always_comb begin
        n_ticks            = r_ticks;
        n_attempts         = r_attempts;
        o_status.timeout   = 1'b0;
        o_status.exhausted = 1'b0;
        if (i_ctrl.clear) begin
            n_ticks    = '0;
            n_attempts = '0;
        end else if (i_ctrl.tick) begin
            if (expired) begin
                n_ticks            = '0;
                n_attempts         = attempts_inc;
                o_status.timeout   = 1'b1;
                o_status.exhausted = (attempts_inc >= i_max_attempts);
            end else begin
                n_ticks = ticks_inc;
            end
        end
    end

endmodule

`default_nettype wire

[sim/tb_supervisory_frame_arq_receiver.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the supervisory frame ARQ receiver top level.
// Depends on sfar_pkg and supervisory_frame_arq_receiver; a scoreboard class predicts each word.

module tb_supervisory_frame_arq_receiver;
    import sfar_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET = 1200;
    localparam int         PHASE_COUNT = 8;

    typedef struct packed {
        logic       transmit;
        logic       done;
        logic [3:0] code;
        logic       busy;
    } t_reply;

    // Tracks the sender and recognizer state and holds the replies still owed by the block.
    class arq_scoreboard;
        logic [7:0]  addr_reg;
        logic [15:0] timeout_reg;
        logic [3:0]  attempts_reg;
        bit          waiting;
        t_rx_phase   phase;
        logic [7:0]  ctl;
        logic [3:0]  attempts;
        logic [15:0] ticks;
        t_reply      owed[$];
        int          errors;

        function new();
            addr_reg     = ADDR_RESET;
            timeout_reg  = TIMEOUT_RESET;
            attempts_reg = ATTEMPT_RESET;
            waiting      = 1'b0;
            phase        = PH_HUNT;
            ctl          = 8'h00;
            attempts     = 4'd0;
            ticks        = 16'd0;
            errors       = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [15:0] data);
            case (idx)
                REG_ADDRESS:  addr_reg = data[7:0];
                REG_TIMEOUT:  timeout_reg = data;
                REG_ATTEMPTS: attempts_reg = data[3:0];
                default: ;
            endcase
        endfunction

        function t_result decode_control(logic [7:0] c);
            case (c)
                CTL_UA:   return RES_UA;
                CTL_RR0:  return RES_RR0;
                CTL_RR1:  return RES_RR1;
                CTL_REJ0: return RES_REJ0;
                CTL_REJ1: return RES_REJ1;
                CTL_DISC: return RES_DISC;
                default:  return RES_UNKNOWN;
            endcase
        endfunction

        function void note_input(logic [1:0] cmd, logic [7:0] b, logic ua);
            t_reply r;
            r.transmit = 1'b0;
            r.done     = 1'b0;
            r.code     = RES_NONE;
            if (cmd == CMD_START) begin
                r.transmit = 1'b1;
                phase      = PH_HUNT;
                attempts   = 4'd0;
                ticks      = 16'd0;
                if (ua) begin
                    waiting = 1'b0;
                    r.done  = 1'b1;
                    r.code  = RES_UA_SENT;
                end else begin
                    waiting = 1'b1;
                end
            end else if (cmd == CMD_BYTE && waiting) begin
                case (phase)
                    PH_HUNT: begin
                        if (b == FRAME_FLAG) phase = PH_FLAG;
                    end
                    PH_FLAG: begin
                        // The address match is tested first, so a flag-valued address works.
                        if (b == addr_reg) phase = PH_ADDR;
                        else if (b == FRAME_FLAG) phase = PH_FLAG;
                        else phase = PH_HUNT;
                    end
                    PH_ADDR: begin
                        if (b == FRAME_FLAG) begin
                            phase = PH_FLAG;
                        end else begin
                            ctl   = b;
                            phase = PH_CTRL;
                        end
                    end
                    PH_CTRL: begin
                        if (b == FRAME_FLAG) phase = PH_FLAG;
                        else if (b == (addr_reg ^ ctl)) phase = PH_BCC;
                        else phase = PH_HUNT;
                    end
                    PH_BCC: begin
                        if (b == FRAME_FLAG) begin
                            r.done  = 1'b1;
                            r.code  = decode_control(ctl);
                            waiting = 1'b0;
                        end
                        phase = PH_HUNT;
                    end
                    default: phase = PH_HUNT;
                endcase
            end else if (cmd == CMD_TICK && waiting) begin
                ticks = ticks + 16'd1;
                // A zero limit compares as always reached, which acts as a limit of one.
                if (ticks >= timeout_reg) begin
                    ticks    = 16'd0;
                    attempts = attempts + 4'd1;
                    phase    = PH_HUNT;
                    if (attempts >= attempts_reg) begin
                        waiting = 1'b0;
                        r.done  = 1'b1;
                        r.code  = RES_EXHAUSTED;
                    end else begin
                        r.transmit = 1'b1;
                    end
                end
            end
            r.busy = waiting;
            owed.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task check_result(t_reply got);
            t_reply want;
            if (owed.size() == 0) begin
                report($sformatf("result word with none owed: tx=%0d done=%0d code=%0d busy=%0d",
                                 got.transmit, got.done, got.code, got.busy));
                return;
            end
            want = owed.pop_front();
            if (got.transmit !== want.transmit)
                report($sformatf("transmit got %0d want %0d", got.transmit, want.transmit));
            if (got.done !== want.done)
                report($sformatf("done got %0d want %0d", got.done, want.done));
            if (got.code !== want.code)
                report($sformatf("result_code got %0d want %0d", got.code, want.code));
            if (got.busy !== want.busy)
                report($sformatf("busy got %0d want %0d", got.busy, want.busy));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_command     = 2'd0;
    logic [7:0]  i_rx_byte     = 8'd0;
    logic        i_frame_is_ua = 1'b0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_transmit;
    logic        o_done_res;
    logic [3:0]  o_result_code;
    logic        o_busy_res;

    arq_scoreboard sb = new();
    bit            idling = 1'b1;
    int            counted = 0;

    supervisory_frame_arq_receiver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_rx_byte     (i_rx_byte),
        .i_frame_is_ua (i_frame_is_ua),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_transmit    (o_transmit),
        .o_done_res    (o_done_res),
        .o_result_code (o_result_code),
        .o_busy_res    (o_busy_res)
    );

    always #2 i_clk = ~i_clk;

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic ua);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_rx_byte     <= b;
        i_frame_is_ua <= ua;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_START || sb.waiting) counted++;
        sb.note_input(cmd, b, ua);
    endtask

    task automatic tx_start(logic ua);
        send_word(CMD_START, 8'($urandom), ua);
    endtask

    task automatic tx_byte(logic [7:0] b);
        send_word(CMD_BYTE, b, 1'($urandom));
    endtask

    task automatic tx_tick();
        send_word(CMD_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(t_reg_index idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Upper data bits beyond a register's width are junk and must be dropped by the block.
    task automatic set_config(logic [7:0] addr, logic [15:0] tmo, logic [3:0] att);
        write_reg(REG_ADDRESS, {8'($urandom), addr});
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_ATTEMPTS, {12'($urandom), att});
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // flaw: 0 clean frame, 1 corrupted BCC, 2 cut short.
    task automatic send_reply(logic [7:0] ctl, int flaw);
        logic [7:0] bytes [5];
        int         n;
        bytes[0] = FRAME_FLAG;
        bytes[1] = sb.addr_reg;
        bytes[2] = ctl;
        bytes[3] = sb.addr_reg ^ ctl;
        bytes[4] = FRAME_FLAG;
        n = 5;
        if (flaw == 1) bytes[3] = bytes[3] ^ 8'($urandom_range(1, 255));
        if (flaw == 2) n = $urandom_range(1, 4);
        if ($urandom_range(0, 5) == 0) tx_byte(FRAME_FLAG);
        for (int i = 0; i < n; i++) tx_byte(bytes[i]);
    endtask

    function automatic logic [7:0] pick_control();
        case ($urandom_range(0, 8))
            0: return CTL_UA;
            1: return CTL_RR0;
            2: return CTL_RR1;
            3: return CTL_REJ0;
            4: return CTL_REJ1;
            5: return CTL_DISC;
            6: return sb.addr_reg ^ FRAME_FLAG;  // its BCC looks like a flag
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_transaction();
        int events;
        int sel;
        int burst;
        int eff_tmo;
        if ($urandom_range(0, 9) == 0) begin
            tx_start(1'b1);
        end else begin
            tx_start(1'b0);
            events = $urandom_range(1, 5);
            while (sb.waiting && events > 0) begin
                events--;
                sel = $urandom_range(0, 19);
                if (sel < 9) begin
                    send_reply(pick_control(), 0);
                end else if (sel < 12) begin
                    send_reply(pick_control(), $urandom_range(1, 2));
                end else if (sel < 14) begin
                    repeat ($urandom_range(1, 4)) tx_byte(8'($urandom));
                end else if (sel < 18) begin
                    eff_tmo = (sb.timeout_reg == 16'd0) ? 1 : int'(sb.timeout_reg);
                    burst = $urandom_range(1, (eff_tmo > 20) ? 40 : 2 * eff_tmo);
                    for (int k = 0; k < burst && sb.waiting; k++) tx_tick();
                end else if (sel == 18) begin
                    send_word(CMD_UNUSED, 8'($urandom), 1'($urandom));
                end else begin
                    tx_start(1'b0);
                end
            end
        end
        // Now and then a stray word arrives after the transaction, while the block may still be waiting.
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0: tx_tick();
                1: tx_byte(8'($urandom));
                default: send_word(CMD_UNUSED, 8'($urandom), 1'($urandom));
            endcase
        end
    endtask

    initial begin : result_monitor
        t_reply got;
        int     stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.transmit = o_transmit;
                got.done     = o_done_res;
                got.code     = o_result_code;
                got.busy     = o_busy_res;
                sb.check_result(got);
            end
            if (stall_left > 0) stall_left--;
            else if (idling && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
            i_out_stall <= (stall_left != 0);
        end
    end

    initial begin : stimulus
        int goal;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset configuration (address 3).
        tx_start(1'b1);
        tx_byte(8'hFF);
        tx_tick();
        tx_start(1'b0);
        send_word(CMD_UNUSED, 8'h00, 1'b1);
        tx_byte(FRAME_FLAG);
        tx_byte(FRAME_FLAG);
        tx_byte(8'h03);
        tx_byte(FRAME_FLAG);
        tx_byte(8'h03);
        tx_byte(CTL_RR0);
        tx_byte(8'h03 ^ CTL_RR0);
        tx_byte(FRAME_FLAG);
        tx_start(1'b0);
        tx_byte(FRAME_FLAG);
        tx_byte(8'h03);
        tx_byte(8'h7D);
        tx_byte(FRAME_FLAG);
        tx_byte(8'h03);
        tx_byte(CTL_UA);
        tx_byte(8'h00);
        tx_tick();
        tx_start(1'b0);
        send_reply(CTL_DISC, 0);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_config(FRAME_FLAG, 16'd1, 4'd1);
                1: set_config(8'h00, 16'd0, 4'd0);
                2: set_config(8'hFF, 16'hFFFF, 4'd15);
                3: set_config(8'h03, 16'd1, 4'd15);
                default: set_config(8'($urandom), 16'($urandom_range(1, 6)),
                                    4'($urandom_range(1, 15)));
            endcase
            idling = (p < PHASE_COUNT - 1);
            goal = counted + ITEM_TARGET / PHASE_COUNT;
            while (counted < goal) random_transaction();
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_supervisory_frame_arq_receiver: PASS");
        end else begin
            $display("tb_supervisory_frame_arq_receiver: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb_supervisory_frame_arq_receiver: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sfar_pkg.sv
hw/rtl/sfar_frame_rx.sv
hw/rtl/sfar_timer.sv
hw/rtl/supervisory_frame_arq_receiver.sv
sim/tb_supervisory_frame_arq_receiver.sv
